// File: rtl/core/door_lock_motor_sequencer_assert.svh
// ----------------------------------------------------------------------------
// door lock motor sequencer assertion macros
// clocked concurrent assertions, disabled while reset is held
// ----------------------------------------------------------------------------
`ifndef DOOR_LOCK_MOTOR_SEQUENCER_ASSERT_SVH
`define DOOR_LOCK_MOTOR_SEQUENCER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define DLMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication into the next cycle
`define DLMS_ASSERT_NEXT(label, ante, cons, msg) \
    `DLMS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/core/dlms_pkg.sv
// ----------------------------------------------------------------------------
// dlms_pkg
// types and constants of the door lock motor sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package dlms_pkg;

    localparam int TIMEOUT_W = 16;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd6000;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_LOCK      = 3'd1,
        ST_LOCKING   = 3'd2,
        ST_UNLOCK    = 3'd3,
        ST_UNLOCKING = 3'd4
    } t_seq_state;

    typedef enum logic [1:0] {
        BAR_POS_UNKNOWN  = 2'd0,
        BAR_POS_LOCKED   = 2'd1,
        BAR_POS_UNLOCKED = 2'd2
    } t_bar_pos;

    typedef enum logic [1:0] {
        WANT_LOCKED   = 2'd0,
        WANT_UNLOCKED = 2'd1,
        WANT_NEITHER  = 2'd2,
        WANT_NONE3    = 2'd3
    } t_want;

endpackage

`default_nettype wire

// File: rtl/core/door_lock_motor_sequencer.sv
// ----------------------------------------------------------------------------
// door_lock_motor_sequencer
// decodes lock contacts and sequences the bolt motor, one request per tick
// ----------------------------------------------------------------------------
//   channel    dir  width  content
//   s_axis     in   8      one tick of contact levels and wanted state
//   m_axis     out  16     status flags, motor drive and sequencer state
//   cfg        in   16     motor timeout register
//
// one request per cycle while no result is stalled; each result is registered, valid the cycle after acceptance
// the path is the sequencer next-state logic and a 16-bit decrement
// reset is synchronous active low, sequencer starts in lock, timeout 6000
// a stalled result is held; a new request is taken in the cycle it leaves
// ----------------------------------------------------------------------------
`default_nettype none

module door_lock_motor_sequencer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // desired_state[1:0], door_open_level[2], reed_level[3], handle_level[4],
    // locked_level[5], unlocked_level[6], bar_level[7]
    input  wire logic [dlms_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // motor_drive[0], door_shut[1], handle_pressed[2], lock_locked[3],
    // lock_unlocked[4], lock_manual_unlocked[5], control_state[8:6],
    // bar_position[10:9], zero[15:11]
    output logic [dlms_pkg::OUT_W-1:0]        o_m_axis_tdata,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [dlms_pkg::TIMEOUT_W-1:0] i_cfg_data
);

    dlms_pkg::t_seq_state              r_state, n_state;
    dlms_pkg::t_bar_pos                r_bar_pos, n_bar_pos;
    logic [dlms_pkg::TIMEOUT_W-1:0]    r_count, n_count;
    logic [dlms_pkg::TIMEOUT_W-1:0]    r_timeout;
    logic                              r_prev_bar;
    logic                              r_motor, n_motor;
    logic                              r_m_valid;
    logic [dlms_pkg::OUT_W-1:0]        r_m_data;

    logic                              accept;
    dlms_pkg::t_want                   want;
    logic                              door_hi, reed_hi, handle_hi;
    logic                              locked_hi, unlocked_hi, bar;
    logic                              closed, handle;
    logic [dlms_pkg::TIMEOUT_W-1:0]    dec_count;

    assign o_s_axis_tready = i_rst_n && (!r_m_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = i_rst_n;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    assign want        = dlms_pkg::t_want'(i_s_axis_tdata[1:0]);
    assign door_hi     = i_s_axis_tdata[2];
    assign reed_hi     = i_s_axis_tdata[3];
    assign handle_hi   = i_s_axis_tdata[4];
    assign locked_hi   = i_s_axis_tdata[5];
    assign unlocked_hi = i_s_axis_tdata[6];
    assign bar         = i_s_axis_tdata[7];

    assign closed    = !door_hi && !reed_hi;
    assign handle    = !handle_hi;
    assign dec_count = r_count - 1'b1;

    always_comb begin
        n_state   = r_state;
        n_bar_pos = r_bar_pos;
        n_count   = r_count;
        n_motor   = r_motor;
        case (r_state)
            dlms_pkg::ST_IDLE: begin
                if (want == dlms_pkg::WANT_LOCKED
                    && r_bar_pos != dlms_pkg::BAR_POS_LOCKED) begin
                    n_state = dlms_pkg::ST_LOCK;
                end else if (want == dlms_pkg::WANT_UNLOCKED
                             && r_bar_pos != dlms_pkg::BAR_POS_UNLOCKED) begin
                    n_state = dlms_pkg::ST_UNLOCK;
                end else if (r_bar_pos == dlms_pkg::BAR_POS_UNKNOWN) begin
                    // locking without motor or counter reload
                    n_state = dlms_pkg::ST_LOCKING;
                end
            end
            dlms_pkg::ST_LOCK: begin
                if (closed && !handle) begin
                    n_motor = 1'b1;
                    n_state = dlms_pkg::ST_LOCKING;
                    n_count = r_timeout;
                end
            end
            dlms_pkg::ST_LOCKING: begin
                if (r_prev_bar && !bar) begin
                    n_motor   = 1'b0;
                    n_state   = dlms_pkg::ST_IDLE;
                    n_count   = '0;
                    n_bar_pos = dlms_pkg::BAR_POS_LOCKED;
                end else begin
                    n_count = dec_count;
                    if (dec_count == '0) begin
                        n_motor = 1'b0;
                        n_state = dlms_pkg::ST_IDLE;
                    end
                end
            end
            dlms_pkg::ST_UNLOCK: begin
                if (closed && !handle) begin
                    n_motor = 1'b1;
                    n_state = dlms_pkg::ST_UNLOCKING;
                    n_count = r_timeout;
                end
            end
            dlms_pkg::ST_UNLOCKING: begin
                if (!r_prev_bar && bar) begin
                    n_motor   = 1'b0;
                    n_state   = dlms_pkg::ST_IDLE;
                    n_count   = '0;
                    n_bar_pos = dlms_pkg::BAR_POS_UNLOCKED;
                end else begin
                    n_count = dec_count;
                    if (dec_count == '0) begin
                        n_motor = 1'b0;
                        n_state = dlms_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_motor = 1'b0;
                n_state = dlms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dlms_pkg::ST_LOCK;
            r_bar_pos  <= dlms_pkg::BAR_POS_UNKNOWN;
            r_count    <= '0;
            r_prev_bar <= 1'b0;
            r_motor    <= 1'b0;
        end else if (accept) begin
            r_state    <= n_state;
            r_bar_pos  <= n_bar_pos;
            r_count    <= n_count;
            r_prev_bar <= bar;
            r_motor    <= n_motor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= dlms_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= {5'b0, n_bar_pos, n_state, !unlocked_hi && bar,
                         !unlocked_hi && !bar, !locked_hi, handle, closed, n_motor};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dlms_checker.sv
// ----------------------------------------------------------------------------
// dlms_checker
// port-level checks of the door lock motor sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "door_lock_motor_sequencer_assert.svh"

module dlms_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    input  wire logic                           o_s_axis_tready,
    input  wire logic [dlms_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  wire logic                           o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [dlms_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           o_cfg_ready
);

    logic s_acc;
    logic cfg_acc;
    logic [2:0] out_state;

    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign out_state = o_m_axis_tdata[8:6];

    // stalled result stays put
    `DLMS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // a request taken without a config write yields a result whose closed flag decodes its contacts
    `DLMS_ASSERT_NEXT(a_closed_flag, s_acc && !cfg_acc,
        o_m_axis_tvalid && (o_m_axis_tdata[1] ==
            (!$past(i_s_axis_tdata[2]) && !$past(i_s_axis_tdata[3]))),
        "result missing or door closed flag wrong")

    // motor runs only while locking or unlocking
    `DLMS_ASSERT(a_motor_state, o_m_axis_tvalid && o_m_axis_tdata[0] |->
        (out_state == dlms_pkg::ST_LOCKING || out_state == dlms_pkg::ST_UNLOCKING),
        "motor driven outside a motor state")

    // empty output stage never blocks the input
    `DLMS_ASSERT(a_ready_empty, !o_m_axis_tvalid |-> o_s_axis_tready,
        "input stalled with empty output stage")

endmodule

bind door_lock_motor_sequencer dlms_checker u_dlms_checker (.*);

`default_nettype wire
